/* rtl/ssr_pkg.sv */
// shared constants and types for the stream sentinel remover
package ssr_pkg;

    localparam int MAX_SENTINEL_DEF = 16;
    localparam int SENT_BYTES_MAX   = 16;
    localparam int CFG_DATA_W       = 64;
    localparam int CFG_LEN_W        = 5;
    localparam int CFG_ADDR_W       = 2;
    localparam int IN_TDATA_W       = 8;
    localparam int OUT_TDATA_W      = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SENT_LO = 2'd0,
        CFG_SENT_HI = 2'd1,
        CFG_SENT_LEN = 2'd2
    } cfg_addr_t;

    typedef enum logic {
        FUNC_DATA  = 1'b0,
        FUNC_FLUSH = 1'b1
    } func_t;

    typedef struct packed {
        logic match;
        logic win_full;
    } match_stat_t;

endpackage

/* rtl/stream_sentinel_remover.sv */
// stream sentinel remover top level: input register, hold window, result register
// a beat enters the input register; its result is then registered in the result register
// one data beat per cycle unless the output stalls; a flush sends each held byte or one empty beat
// the hold window is a register array shifted in place and compared combinationally
// reset clears the hold count, sentinel bytes and both beat valid flags; the length resets to 1
// held bytes and beat payloads themselves are not reset
module stream_sentinel_remover #(
    parameter int MAX_SENTINEL = ssr_pkg::MAX_SENTINEL_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ssr_pkg::IN_TDATA_W-1:0]    s_tdata,   // data_byte[7:0]
    input  logic                              s_tuser,   // func[0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ssr_pkg::OUT_TDATA_W-1:0]   m_tdata,   // out_byte[7:0], byte_valid[8], found[9], pad
    output logic                              m_tlast,   // last
    input  logic                              cfg_we,
    input  logic [ssr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW         = $clog2(MAX_SENTINEL);
    localparam int HOLD_DEPTH = MAX_SENTINEL - 1;
    localparam logic [ssr_pkg::CFG_LEN_W-1:0] LEN_MAX = ssr_pkg::CFG_LEN_W'(MAX_SENTINEL);

    logic [ssr_pkg::CFG_DATA_W-1:0] sent_lo_reg;
    logic [ssr_pkg::CFG_DATA_W-1:0] sent_hi_reg;
    logic [ssr_pkg::CFG_LEN_W-1:0]  sent_len_reg;

    logic                           in_valid_reg;
    ssr_pkg::func_t                 in_func_reg;
    logic [7:0]                     in_byte_reg;

    logic [HOLD_DEPTH-1:0][7:0]     hold_reg;
    logic [HOLD_DEPTH-1:0][7:0]     hold_next;
    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  count_next;

    logic                           out_valid_reg;
    logic [7:0]                     out_byte_reg;
    logic                           out_bvalid_reg;
    logic                           out_found_reg;
    logic                           out_last_reg;

    logic [CW-1:0]                  keep;
    logic                           advance;
    logic                           work;
    logic                           in_done;
    logic                           is_flush;
    logic                           shift;
    logic                           insert;
    logic [CW-1:0]                  ins_pos;
    ssr_pkg::match_stat_t           stat;

    logic                           res_valid;
    logic [7:0]                     res_byte;
    logic                           res_bvalid;
    logic                           res_found;
    logic                           res_last;

    always_comb
    begin
        if (sent_len_reg == '0)
        begin
            keep = '0;
        end
        else if (sent_len_reg > LEN_MAX)
        begin
            keep = CW'(HOLD_DEPTH);
        end
        else
        begin
            keep = CW'(sent_len_reg - ssr_pkg::CFG_LEN_W'(1));
        end
    end

    ssr_match #(
        .MAX_SENTINEL (MAX_SENTINEL)
    ) u_match (
        .hold      (hold_reg),
        .sentinel  ({sent_hi_reg, sent_lo_reg}),
        .keep      (keep),
        .count     (count_reg),
        .data_byte (in_byte_reg),
        .stat      (stat)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign work     = in_valid_reg && advance;
    assign is_flush = (in_func_reg == ssr_pkg::FUNC_FLUSH);
    assign in_done  = work && (!is_flush || count_reg <= CW'(1));
    assign s_tready = !in_valid_reg || in_done;

    // result of the item at the head of the input register
    always_comb
    begin
        res_valid  = 1'b0;
        res_byte   = 8'd0;
        res_bvalid = 1'b0;
        res_found  = 1'b0;
        res_last   = 1'b0;
        if (is_flush)
        begin
            res_valid = 1'b1;
            res_last  = (count_reg <= CW'(1));
            if (count_reg != '0)
            begin
                res_byte   = hold_reg[0];
                res_bvalid = 1'b1;
            end
        end
        else if (stat.win_full)
        begin
            res_valid = 1'b1;
            if (stat.match)
            begin
                res_found = 1'b1;
            end
            else
            begin
                res_bvalid = 1'b1;
                res_byte   = (count_reg == '0) ? in_byte_reg : hold_reg[0];
            end
        end
    end

    // hold window update
    always_comb
    begin
        shift   = work && (is_flush || (stat.win_full && !stat.match && count_reg != '0));
        insert  = work && !is_flush && !(stat.win_full && (stat.match || count_reg == '0));
        ins_pos = stat.win_full ? count_reg - CW'(1) : count_reg;
        for (int i = 0; i < HOLD_DEPTH; i++)
        begin
            hold_next[i] = hold_reg[i];
            if (shift && i < HOLD_DEPTH - 1)
            begin
                hold_next[i] = hold_reg[i + 1];
            end
            if (insert && ins_pos == CW'(i))
            begin
                hold_next[i] = in_byte_reg;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cfg_we && cfg_addr == ssr_pkg::CFG_SENT_LEN)
        begin
            count_next = '0;
        end
        else if (work)
        begin
            if (is_flush)
            begin
                count_next = (count_reg == '0) ? '0 : count_reg - CW'(1);
            end
            else if (!stat.win_full)
            begin
                count_next = count_reg + CW'(1);
            end
            else if (stat.match)
            begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_lo_reg  <= '0;
            sent_hi_reg  <= '0;
            sent_len_reg <= ssr_pkg::CFG_LEN_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ssr_pkg::CFG_SENT_LO:  sent_lo_reg  <= cfg_data;
                ssr_pkg::CFG_SENT_HI:  sent_hi_reg  <= cfg_data;
                ssr_pkg::CFG_SENT_LEN: sent_len_reg <= cfg_data[ssr_pkg::CFG_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= work && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        if (s_tvalid && s_tready)
        begin
            in_func_reg <= ssr_pkg::func_t'(s_tuser);
            in_byte_reg <= s_tdata[7:0];
        end
        if (advance)
        begin
            out_byte_reg   <= res_byte;
            out_bvalid_reg <= res_bvalid;
            out_found_reg  <= res_found;
            out_last_reg   <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_found_reg, out_bvalid_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;

    a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= keep)
        else $error("hold count beyond window");

    a_found_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_found_reg |-> !out_bvalid_reg && !out_last_reg)
        else $error("found beat carries byte or last");

    a_match_clears: assert property (@(posedge clk) disable iff (!rst_n)
        work && !is_flush && stat.win_full && stat.match |=> count_reg == '0)
        else $error("window not cleared after match");

    a_flush_drains: assert property (@(posedge clk) disable iff (!rst_n)
        work && is_flush && count_reg <= CW'(1) |=> count_reg == '0)
        else $error("flush left bytes held");

    a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
        work && is_flush && count_reg > CW'(1) |-> !s_tready)
        else $error("new beat taken during flush drain");

endmodule

/* rtl/ssr_match.sv */
// parallel window compare of held bytes plus incoming byte against the sentinel
module ssr_match #(
    parameter int MAX_SENTINEL = ssr_pkg::MAX_SENTINEL_DEF,
    localparam int CW          = $clog2(MAX_SENTINEL),
    localparam int HOLD_DEPTH  = MAX_SENTINEL - 1
) (
    input  logic [HOLD_DEPTH-1:0][7:0]               hold,
    input  logic [ssr_pkg::SENT_BYTES_MAX-1:0][7:0]  sentinel,
    input  logic [CW-1:0]                            keep,
    input  logic [CW-1:0]                            count,
    input  logic [7:0]                               data_byte,
    output ssr_pkg::match_stat_t                     stat
);

    logic [7:0] tail_byte;
    logic       hold_ok;

    always_comb
    begin
        tail_byte = 8'd0;
        for (int k = 0; k < MAX_SENTINEL; k++)
        begin
            if (keep == CW'(k))
            begin
                tail_byte = sentinel[k];
            end
        end
    end

    always_comb
    begin
        hold_ok = 1'b1;
        for (int i = 0; i < HOLD_DEPTH; i++)
        begin
            if (CW'(i) < keep && hold[i] != sentinel[i])
            begin
                hold_ok = 1'b0;
            end
        end
    end

    assign stat.win_full = (count == keep);
    assign stat.match    = hold_ok && (tail_byte == data_byte);

endmodule

/* sim/testbench.sv */
// self-checking testbench for the stream sentinel remover
module testbench;

    localparam int HOLD_DEPTH  = ssr_pkg::MAX_SENTINEL_DEF - 1;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic       last;
        logic       found;
        logic       byte_valid;
        logic [7:0] text_byte;
    } out_beat_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [ssr_pkg::IN_TDATA_W-1:0]  s_tdata;    // data_byte[7:0]
    logic                            s_tuser;    // func[0]
    logic                            m_tvalid;
    logic                            m_tready;
    logic [ssr_pkg::OUT_TDATA_W-1:0] m_tdata;    // out_byte[7:0], byte_valid[8], found[9], pad
    logic                            m_tlast;
    logic                            cfg_we;
    logic [ssr_pkg::CFG_ADDR_W-1:0]  cfg_addr;
    logic [ssr_pkg::CFG_DATA_W-1:0]  cfg_data;

    // predictor state
    logic [63:0]    pat_lo;
    logic [63:0]    pat_hi;
    logic [4:0]     pat_len;
    logic [7:0]     held_bytes [0:HOLD_DEPTH-1];
    int unsigned    held_count;
    out_beat_t      out_expected [$];

    int unsigned    send_idle;
    int unsigned    recv_idle;
    int unsigned    hold_off_len;
    int unsigned    hold_off_seq;
    int unsigned    items_sent;
    int unsigned    flushes;
    int unsigned    removals;
    int unsigned    beats_out;
    int unsigned    mismatches;
    int unsigned    stall_cycles;
    out_beat_t      want;

    stream_sentinel_remover uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned active_len();
        int unsigned n;
        n = pat_len;
        if (n == 0) n = 1;
        if (n > ssr_pkg::MAX_SENTINEL_DEF) n = ssr_pkg::MAX_SENTINEL_DEF;
        return n;
    endfunction

    function automatic logic [7:0] pattern_byte(input int unsigned k);
        if (k < 8) return pat_lo[8*k +: 8];
        if (k < 16) return pat_hi[8*(k-8) +: 8];
        return 8'h00;
    endfunction

    function automatic out_beat_t beat_of(input logic [7:0] b, input logic v,
                                          input logic f, input logic l);
        out_beat_t r;
        r.text_byte  = b;
        r.byte_valid = v;
        r.found      = f;
        r.last       = l;
        return r;
    endfunction

    // expected output beats for one accepted input beat
    task automatic remover_predict(input ssr_pkg::func_t f, input logic [7:0] b);
        int unsigned keep;
        int unsigned base;
        int unsigned k;
        logic        hit;
        keep = active_len() - 1;
        if (f == ssr_pkg::FUNC_FLUSH)
        begin
            flushes++;
            if (held_count == 0)
                out_expected.push_back(beat_of(8'h00, 1'b0, 1'b0, 1'b1));
            else
                for (k = 0; k < held_count; k++)
                    out_expected.push_back(beat_of(held_bytes[k], 1'b1, 1'b0,
                                                   k + 1 == held_count));
            held_count = 0;
        end
        else if (held_count < keep)
        begin
            held_bytes[held_count] = b;
            held_count++;
        end
        else
        begin
            hit  = (pattern_byte(keep) == b);
            base = held_count - keep;
            for (k = 0; k < keep; k++)
                if (held_bytes[base + k] != pattern_byte(k)) hit = 1'b0;
            if (hit)
            begin
                held_count = 0;
                removals++;
                out_expected.push_back(beat_of(8'h00, 1'b0, 1'b1, 1'b0));
            end
            else if (held_count == 0)
            begin
                out_expected.push_back(beat_of(b, 1'b1, 1'b0, 1'b0));
            end
            else
            begin
                out_expected.push_back(beat_of(held_bytes[0], 1'b1, 1'b0, 1'b0));
                for (k = 1; k < held_count; k++) held_bytes[k-1] = held_bytes[k];
                held_bytes[held_count-1] = b;
            end
        end
    endtask

    task automatic send_beat(input ssr_pkg::func_t f, input logic [7:0] b);
        while (send_idle != 0 && $urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= f;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        remover_predict(f, b);
        items_sent++;
    endtask

    // stop offering and wait until every expected beat is out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (out_expected.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input ssr_pkg::cfg_addr_t a, input logic [63:0] d);
        cfg_we   <= 1'b1;
        cfg_addr <= a;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (a)
            ssr_pkg::CFG_SENT_LO: pat_lo = d;
            ssr_pkg::CFG_SENT_HI: pat_hi = d;
            ssr_pkg::CFG_SENT_LEN:
            begin
                pat_len    = d[4:0];
                held_count = 0;
            end
            default: ;
        endcase
    endtask

    task automatic test_reset_state();
        send_beat(ssr_pkg::FUNC_DATA, 8'h00);
        send_beat(ssr_pkg::FUNC_DATA, 8'hA5);
        send_beat(ssr_pkg::FUNC_FLUSH, 8'hFF);
    endtask

    task automatic test_length_limits();
        settle();
        write_reg(ssr_pkg::CFG_SENT_LO, '1);
        write_reg(ssr_pkg::CFG_SENT_LEN, 64'd0);
        send_beat(ssr_pkg::FUNC_DATA, 8'hFF);
        settle();
        write_reg(ssr_pkg::CFG_SENT_HI, '1);
        write_reg(ssr_pkg::CFG_SENT_LEN, ({$urandom, $urandom} & ~64'h1F) | 64'd31);
        repeat (15) send_beat(ssr_pkg::FUNC_DATA, 8'hFF);
        send_beat(ssr_pkg::FUNC_DATA, 8'h00);
        send_beat(ssr_pkg::FUNC_FLUSH, 8'h5A);
    endtask

    task automatic test_held_bytes();
        settle();
        write_reg(ssr_pkg::CFG_SENT_LO, 64'h636261);
        write_reg(ssr_pkg::CFG_SENT_LEN, 64'd3);
        send_beat(ssr_pkg::FUNC_DATA, 8'h61);
        send_beat(ssr_pkg::FUNC_DATA, 8'h62);
        settle();
        // byte rewrite keeps the held window
        write_reg(ssr_pkg::CFG_SENT_LO, 64'h646261);
        send_beat(ssr_pkg::FUNC_DATA, 8'h64);
        send_beat(ssr_pkg::FUNC_DATA, 8'h71);
        send_beat(ssr_pkg::FUNC_DATA, 8'h72);
        settle();
        // length rewrite drops it
        write_reg(ssr_pkg::CFG_SENT_LEN, 64'd3);
        send_beat(ssr_pkg::FUNC_FLUSH, 8'h00);
    endtask

    task automatic test_overlap();
        settle();
        write_reg(ssr_pkg::CFG_SENT_LO, 64'h6161);
        write_reg(ssr_pkg::CFG_SENT_LEN, 64'd2);
        repeat (3) send_beat(ssr_pkg::FUNC_DATA, 8'h61);
        send_beat(ssr_pkg::FUNC_FLUSH, 8'h80);
    endtask

    task automatic pick_setting();
        int unsigned style;
        int unsigned n;
        int unsigned k;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0]  a0;
        logic [7:0]  a1;
        style = $urandom_range(9);
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        a0 = 8'($urandom);
        a1 = 8'($urandom);
        if (style == 0)
        begin
            lo = '0;
            hi = '0;
        end
        else if (style == 1)
        begin
            lo = '1;
            hi = '1;
        end
        else if (style < 6)
        begin
            // two-letter patterns give self-overlapping sentinels
            for (k = 0; k < 8; k++)
            begin
                lo[8*k +: 8] = $urandom_range(1) ? a0 : a1;
                hi[8*k +: 8] = $urandom_range(1) ? a0 : a1;
            end
        end
        case ($urandom_range(5))
            0: n = 1;
            1: n = 16;
            2: n = $urandom_range(2, 4);
            3: n = $urandom_range(8, 9);
            4: n = 15;
            default: n = $urandom_range(1, 16);
        endcase
        write_reg(ssr_pkg::CFG_SENT_LO, lo);
        write_reg(ssr_pkg::CFG_SENT_HI, hi);
        if (n != active_len() || $urandom_range(1))
            write_reg(ssr_pkg::CFG_SENT_LEN, 64'(n));
    endtask

    task automatic random_traffic(input int unsigned n_items);
        int unsigned goal;
        int unsigned len;
        int unsigned r;
        int unsigned bad;
        int unsigned k;
        goal = items_sent + n_items;
        while (items_sent < goal)
        begin
            settle();
            pick_setting();
            len = active_len();
            repeat ($urandom_range(4, 10))
            begin
                r = $urandom_range(99);
                if (r < 45)
                begin
                    // whole sentinel, sometimes with one byte broken
                    bad = ($urandom_range(4) == 0) ? $urandom_range(len - 1) : len;
                    for (k = 0; k < len; k++)
                        send_beat(ssr_pkg::FUNC_DATA,
                                  (k == bad) ? 8'($urandom) : pattern_byte(k));
                end
                else if (r < 75)
                begin
                    repeat ($urandom_range(1, 6))
                        send_beat(ssr_pkg::FUNC_DATA, pattern_byte($urandom_range(len - 1)));
                end
                else if (r < 93)
                begin
                    repeat ($urandom_range(1, 4)) send_beat(ssr_pkg::FUNC_DATA, 8'($urandom));
                end
                else
                begin
                    send_beat(ssr_pkg::FUNC_FLUSH, 8'($urandom));
                end
            end
            if ($urandom_range(1)) send_beat(ssr_pkg::FUNC_FLUSH, 8'($urandom));
        end
    endtask

    task automatic test_output_stall();
        int unsigned k;
        settle();
        write_reg(ssr_pkg::CFG_SENT_LO, {$urandom, $urandom});
        write_reg(ssr_pkg::CFG_SENT_LEN, 64'd4);
        send_idle    = 0;
        hold_off_len = 60;
        hold_off_seq++;
        for (k = 0; k < 40; k++) send_beat(ssr_pkg::FUNC_DATA, 8'($urandom));
        send_beat(ssr_pkg::FUNC_FLUSH, 8'h00);
        settle();
    endtask

    // output side: random stalls plus requested long hold-offs
    initial
    begin : output_side
        int unsigned stall_left;
        int unsigned seen_seq;
        stall_left = 0;
        seen_seq   = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_seq != seen_seq)
            begin
                seen_seq   = hold_off_seq;
                stall_left = hold_off_len;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_out++;
            if (out_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: tdata %h tlast %b", m_tdata, m_tlast);
            end
            else
            begin
                want = out_expected.pop_front();
                if (m_tdata[7:0] !== want.text_byte || m_tdata[8] !== want.byte_valid ||
                    m_tdata[9] !== want.found || m_tdata[15:10] !== 6'd0 ||
                    m_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: expected byte %h valid %b found %b last %b, got %s",
                                 beats_out, want.text_byte, want.byte_valid, want.found,
                                 want.last,
                                 $sformatf("byte %h valid %b found %b last %b pad %h",
                                           m_tdata[7:0], m_tdata[8], m_tdata[9], m_tlast,
                                           m_tdata[15:10]));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("testbench: errors");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = ssr_pkg::FUNC_DATA;
        cfg_we       = 1'b0;
        cfg_addr     = ssr_pkg::CFG_SENT_LO;
        cfg_data     = '0;
        pat_lo       = '0;
        pat_hi       = '0;
        pat_len      = 5'd1;
        held_count   = 0;
        hold_off_len = 0;
        hold_off_seq = 0;
        items_sent   = 0;
        flushes      = 0;
        removals     = 0;
        beats_out    = 0;
        mismatches   = 0;
        stall_cycles = 0;
        send_idle    = 17;
        recv_idle    = 66;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_length_limits();
        test_held_bytes();
        test_overlap();
        random_traffic(110);

        send_idle = 66;
        recv_idle = 17;
        random_traffic(110);

        recv_idle = 0;
        test_output_stall();
        random_traffic(110);

        settle();
        repeat (8) @(posedge clk);
        $display("run: %0d input beats (%0d flushes), %0d output beats, %0d sentinel removals",
                 items_sent, flushes, beats_out, removals);
        $display("run: sentinel lengths 1 to 16 plus out-of-range, three idle mixes, long stall");
        if (mismatches == 0 && out_expected.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
